### hw/rtl/lkv_pkg.sv
package lkv_pkg;

  localparam int LKV_ENTRIES = 16;
  localparam int LKV_DATA_W  = 32;
  localparam int LKV_CFG_W   = 5;
  localparam int LKV_STAMP_W = 48;
  localparam int LKV_QDEPTH  = 2;

  localparam logic [LKV_CFG_W-1:0] LKV_CAP_RESET = 5'd16;

  localparam logic LKV_CMD_GET = 1'b0;
  localparam logic LKV_CMD_PUT = 1'b1;

  typedef struct packed {
    logic                         command;
    logic signed [LKV_DATA_W-1:0] key;
    logic signed [LKV_DATA_W-1:0] value;
  } lkv_req_t;

  typedef struct packed {
    logic                         hit;
    logic signed [LKV_DATA_W-1:0] read_value;
    logic                         evicted;
    logic signed [LKV_DATA_W-1:0] evicted_key;
  } lkv_rsp_t;

  typedef struct packed {
    logic     valid;
    lkv_req_t req;
  } lkv_fe2be_t;

endpackage

### hw/rtl/lkv_front.sv
module lkv_front import lkv_pkg::*; #(
  parameter int ENTRIES = LKV_ENTRIES,
  localparam int CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lkv_req_t             in_data,
  input  logic                 cfg_we,
  input  logic [LKV_CFG_W-1:0] cfg_wdata,
  input  logic                 pop,
  output lkv_fe2be_t           fe,
  output logic [CNT_W-1:0]     cap_eff
);

  localparam int PTR_W  = (LKV_QDEPTH > 1) ? $clog2(LKV_QDEPTH) : 1;
  localparam int QCNT_W = $clog2(LKV_QDEPTH + 1);
  localparam int CMP_W  = (CNT_W > LKV_CFG_W) ? CNT_W : LKV_CFG_W;

  lkv_req_t             q_mem_r [LKV_QDEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [QCNT_W-1:0]    q_cnt_r;
  logic [LKV_CFG_W-1:0] cap_r;
  logic                 push;
  logic [CMP_W-1:0]     cap_w;
  logic [CMP_W-1:0]     ent_w;
  logic [CMP_W-1:0]     cap_sel;

  assign in_stall  = (q_cnt_r == QCNT_W'(LKV_QDEPTH));
  assign push      = in_valid && !in_stall;
  assign fe.valid  = (q_cnt_r != '0);
  assign fe.req    = q_mem_r[rd_ptr_r];

  always_comb begin
    cap_w = CMP_W'(cap_r);
    ent_w = CMP_W'(ENTRIES);
    if (cap_w == '0) begin
      cap_sel = CMP_W'(1);
    end else if (cap_w > ent_w) begin
      cap_sel = ent_w;
    end else begin
      cap_sel = cap_w;
    end
    cap_eff = CNT_W'(cap_sel);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
      cap_r    <= LKV_CAP_RESET;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(LKV_QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(LKV_QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        q_cnt_r <= q_cnt_r + 1'b1;
      end else if (pop && !push) begin
        q_cnt_r <= q_cnt_r - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/lkv_back.sv
module lkv_back import lkv_pkg::*; #(
  parameter int ENTRIES = LKV_ENTRIES,
  localparam int CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lkv_fe2be_t       fe,
  input  logic [CNT_W-1:0] cap_eff,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output lkv_rsp_t         out_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CNT_W-1:0] ENT_CNT = CNT_W'(ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_RESP   = 4'b1000
  } bk_state_t;

  logic [LKV_DATA_W-1:0]  key_mem   [ENTRIES];
  logic [LKV_DATA_W-1:0]  val_mem   [ENTRIES];
  logic [LKV_STAMP_W-1:0] stamp_mem [ENTRIES];

  bk_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [ENTRIES-1:0]     valid_r;
  logic [CNT_W-1:0]       valid_cnt_r;
  logic [LKV_STAMP_W-1:0] stamp_r;

  logic                   ev_en_r;
  logic                   ev_valid_r;
  logic [IDX_W-1:0]       ev_idx_r;
  logic [LKV_DATA_W-1:0]  key_q_r;
  logic [LKV_STAMP_W-1:0] stamp_q_r;
  logic [LKV_DATA_W-1:0]  val_q_r;

  logic                   found_r;
  logic [IDX_W-1:0]       found_idx_r;
  logic                   free_r;
  logic [IDX_W-1:0]       free_idx_r;
  logic                   old_r;
  logic [IDX_W-1:0]       old_idx_r;
  logic [LKV_STAMP_W-1:0] old_stamp_r;
  logic [LKV_DATA_W-1:0]  old_key_r;

  logic                   rsp_hit_r;
  logic                   rsp_get_hit_r;
  logic                   rsp_ev_r;
  logic [LKV_DATA_W-1:0]  rsp_evkey_r;

  logic                   out_valid_r;
  lkv_rsp_t               out_data_r;

  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic                   is_put;
  logic                   dec;
  logic                   do_evict;
  logic [IDX_W-1:0]       slot;
  logic                   wr_key;
  logic                   wr_val;
  logic                   wr_stamp;
  logic                   vrd_en;
  logic                   load;
  logic                   ev_match;

  assign rd_en    = (state_r == S_SCAN) && (cnt_r != ENT_CNT);
  assign rd_addr  = cnt_r[IDX_W-1:0];
  assign is_put   = (fe.req.command == LKV_CMD_PUT);
  assign dec      = (state_r == S_DECIDE);
  assign do_evict = is_put && !found_r && (valid_cnt_r >= cap_eff);
  assign slot     = found_r ? found_idx_r : (do_evict ? old_idx_r : free_idx_r);
  assign wr_key   = dec && is_put && !found_r;
  assign wr_val   = dec && is_put;
  assign wr_stamp = dec && (found_r || is_put);
  assign vrd_en   = dec && found_r && !is_put;
  assign load     = (state_r == S_RESP) && (!out_valid_r || !out_stall);
  assign pop      = load;
  assign ev_match = ev_valid_r && (key_q_r == fe.req.key);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (fe.valid) begin
          state_nxt = S_SCAN;
          cnt_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (cnt_r == ENT_CNT) begin
          state_nxt = S_DECIDE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DECIDE: state_nxt = S_RESP;
      S_RESP: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      key_q_r    <= key_mem[rd_addr];
      stamp_q_r  <= stamp_mem[rd_addr];
      ev_valid_r <= valid_r[rd_addr];
      ev_idx_r   <= rd_addr;
    end
    if (wr_key) begin
      key_mem[slot] <= fe.req.key;
    end
    if (wr_val) begin
      val_mem[slot] <= fe.req.value;
    end
    if (wr_stamp) begin
      stamp_mem[slot] <= stamp_r;
    end
    if (vrd_en) begin
      val_q_r <= val_mem[found_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ev_en_r && (state_r == S_SCAN)) begin
      if (ev_match && !found_r) begin
        found_idx_r <= ev_idx_r;
      end
      if (!ev_valid_r && !free_r) begin
        free_idx_r <= ev_idx_r;
      end
      if (ev_valid_r && (!old_r || (stamp_q_r < old_stamp_r))) begin
        old_idx_r   <= ev_idx_r;
        old_stamp_r <= stamp_q_r;
        old_key_r   <= key_q_r;
      end
    end
    if (dec) begin
      rsp_hit_r     <= found_r;
      rsp_get_hit_r <= found_r && !is_put;
      rsp_ev_r      <= do_evict;
      rsp_evkey_r   <= do_evict ? old_key_r : '0;
    end
    if (load) begin
      out_data_r.hit         <= rsp_hit_r;
      out_data_r.read_value  <= rsp_get_hit_r ? val_q_r : '0;
      out_data_r.evicted     <= rsp_ev_r;
      out_data_r.evicted_key <= rsp_evkey_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      valid_r     <= '0;
      valid_cnt_r <= '0;
      stamp_r     <= '0;
      ev_en_r     <= 1'b0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      old_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ev_en_r <= rd_en;
      if ((state_r == S_IDLE) && fe.valid) begin
        found_r <= 1'b0;
        free_r  <= 1'b0;
        old_r   <= 1'b0;
      end else if (ev_en_r && (state_r == S_SCAN)) begin
        if (ev_match) begin
          found_r <= 1'b1;
        end
        if (!ev_valid_r) begin
          free_r <= 1'b1;
        end
        if (ev_valid_r) begin
          old_r <= 1'b1;
        end
      end
      if (wr_key) begin
        valid_r[slot] <= 1'b1;
        if (!do_evict) begin
          valid_cnt_r <= valid_cnt_r + 1'b1;
        end
      end
      if (wr_stamp) begin
        stamp_r <= stamp_r + 1'b1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement.
// Input channel in_valid / in_stall / in_data carries one request: a get or
// a put of a 32-bit key (and value on put). Output channel out_valid /
// out_stall / out_data returns exactly one result per request, in order:
// hit, read value of a get hit, and the key evicted by a put of a new key.
// cfg_we / cfg_wdata set how many entries may be held before a put evicts
// (0 acts as 1, values above ENTRIES act as ENTRIES); write it only while
// no request is outstanding.
// A lookup walks the key and use-stamp memories one entry per cycle, followed
// by an update step and a result step; a new lookup starts only after the
// result of the last request is loaded into the output register.
// A two-deep request queue holds the request in work and takes one more;
// in_stall rises while both are held.
// Reset (rst_n low, synchronous) empties the cache and the queue, drops any
// pending result and restores a capacity of 16.
// While out_stall is high the result holds in the output register; the
// cache stops after one more lookup and in_stall rises once the queue fills.
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int ENTRIES = LKV_ENTRIES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lkv_req_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lkv_rsp_t             out_data,
  input  logic                 cfg_we,
  input  logic [LKV_CFG_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  lkv_fe2be_t       fe;
  logic [CNT_W-1:0] cap_eff;
  logic             pop;

  lkv_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pop       (pop),
    .fe        (fe),
    .cap_eff   (cap_eff)
  );

  lkv_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fe        (fe),
    .cap_eff   (cap_eff),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/lkv_checker.sv
module lkv_checker import lkv_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input lkv_rsp_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_drop: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.evicted |-> !out_data.hit)
    else $error("eviction reported on a hit");

  a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.evicted |-> out_data.evicted_key == '0)
    else $error("evicted key without eviction");

  a_value_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_value != '0 |-> out_data.hit && !out_data.evicted)
    else $error("read value on a miss or put");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);
